### rtl/replacement_selection_runs_top_assert.svh
// assertion macros shared by the checker of the run generator
// depends on nothing; included by rsr_check.sv
`ifndef REPLACEMENT_SELECTION_RUNS_TOP_ASSERT_SVH
`define REPLACEMENT_SELECTION_RUNS_TOP_ASSERT_SVH

// implication checked on every rising edge outside reset
`define RSR_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rsr check failed");

// implication checked in the cycle after the condition
`define RSR_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("rsr check failed");

`endif

### rtl/rsr_pkg.sv
// types, constants and helpers of the replacement-selection run generator
// depends on nothing; imported by every rtl module of the block
`default_nettype none

package rsr_pkg;

   localparam int HEAP_SIZE = 3;
   localparam int SYM_W     = 8;

   typedef struct packed {
      logic             valid;
      logic             marked;
      logic [SYM_W-1:0] value;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_FILL,
      MODE_REPLACE,
      MODE_SHIFT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      entry_type     newcomer;
      logic          clear_marks;
   } cell_ctrl_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             run_end;
      logic             stream_end;
   } beat_type;

   // a valid entry orders before or with the newcomer: unmarked first, then by value
   function automatic logic key_le(entry_type a, entry_type x);
      return a.valid && ({a.marked, a.value} <= {x.marked, x.value});
   endfunction

endpackage

`default_nettype wire

### rtl/rsr_cell.sv
// one cell of the sorted store chain: holds one entry, takes from its neighbors
// depends on rsr_pkg
`default_nettype none

module rsr_cell
   import rsr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          first_cell,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     left_entry,
   input  wire entry_type     right_entry,
   output entry_type          entry_ff
);

   entry_type entry_in;
   logic      le_left;
   logic      le_self;
   logic      le_right;

   always_comb begin
      le_left  = key_le(left_entry, ctrl.newcomer);
      le_self  = key_le(entry_ff, ctrl.newcomer);
      le_right = key_le(right_entry, ctrl.newcomer);
      case (ctrl.mode)
         MODE_FILL: begin
            if (le_self) begin
               entry_in = entry_ff;
            end else if (first_cell || le_left) begin
               entry_in = ctrl.newcomer;
            end else begin
               entry_in = left_entry;
            end
         end
         MODE_REPLACE: begin
            if (le_right) begin
               entry_in = right_entry;
            end else if (first_cell || le_self) begin
               entry_in = ctrl.newcomer;
            end else begin
               entry_in = entry_ff;
            end
         end
         MODE_SHIFT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      if (ctrl.clear_marks) begin
         entry_in.marked = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

### rtl/rsr_rsp_reg.sv
// output register of the result channel, refilled in the cycle it drains
// depends on rsr_pkg
`default_nettype none

module rsr_rsp_reg
   import rsr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire beat_type beat,
   input  wire logic     rsp_tready,
   output logic          valid_ff,
   output beat_type      beat_ff
);

   logic valid_in;

   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         beat_ff <= beat;
      end
   end

endmodule

`default_nettype wire

### rtl/replacement_selection_runs_top.sv
// replacement-selection run generator: a sorted chain of store cells and an output register
// depends on rsr_pkg, rsr_cell and rsr_rsp_reg
// a byte taken while the chain is full pushes the head entry into the output register
// throughput: one byte per cycle, held off during a flush or while the result beat stalls
// a byte with tlast is followed by a flush that shifts the cells out, one cell per cycle
// while the output register can take it, during which req_tready is low
// reset (synchronous, active high) empties every cell and the output register
`default_nettype none

module replacement_selection_runs_top
   import rsr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [SYM_W-1:0] req_tdata,   // symbol
   input  wire logic             req_tlast,   // end_of_input
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [SYM_W-1:0] rsp_tdata,   // out_symbol
   output logic                  rsp_tlast,   // run_end
   output logic                  rsp_tuser    // stream_end
);

   entry_type     chain [HEAP_SIZE+2];
   entry_type     cells [HEAP_SIZE];
   entry_type     head;
   entry_type     second;
   cell_ctrl_type ctrl;
   beat_type      beat;
   beat_type      beat_ff;
   logic          flush_ff;
   logic          flush_in;
   logic          can_load;
   logic          accept;
   logic          full;
   logic          new_mark;
   logic          all_marked;
   logic          shift_out;
   logic          load;

   assign head     = cells[0];
   assign second   = cells[1];
   assign full     = cells[HEAP_SIZE-1].valid;
   assign can_load = !rsp_tvalid || rsp_tready;

   assign req_tready = !flush_ff && can_load;
   assign accept     = req_tvalid && req_tready;
   assign shift_out  = flush_ff && can_load;

   assign new_mark   = full && (req_tdata < head.value);
   assign all_marked = full && new_mark && second.marked;

   always_comb begin
      ctrl.newcomer.valid  = 1'b1;
      ctrl.newcomer.marked = new_mark;
      ctrl.newcomer.value  = req_tdata;
      ctrl.clear_marks     = accept && all_marked;
      if (accept) begin
         ctrl.mode = full ? MODE_REPLACE : MODE_FILL;
      end else if (shift_out) begin
         ctrl.mode = MODE_SHIFT;
      end else begin
         ctrl.mode = MODE_HOLD;
      end
   end

   always_comb begin
      chain[0]           = '0;
      chain[HEAP_SIZE+1] = '0;
      for (int i = 0; i < HEAP_SIZE; i++) begin
         chain[i+1] = cells[i];
      end
   end

   for (genvar i = 0; i < HEAP_SIZE; i++) begin : g_cell
      rsr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .first_cell  (i == 0),
         .ctrl        (ctrl),
         .left_entry  (chain[i]),
         .right_entry (chain[i+2]),
         .entry_ff    (cells[i])
      );
   end

   always_comb begin
      beat.symbol = head.value;
      if (shift_out) begin
         beat.run_end    = !second.valid || (head.marked != second.marked);
         beat.stream_end = !second.valid;
      end else begin
         beat.run_end    = all_marked;
         beat.stream_end = 1'b0;
      end
   end

   assign load = (accept && full) || shift_out;

   always_comb begin
      flush_in = flush_ff;
      if (accept && req_tlast) begin
         flush_in = 1'b1;
      end else if (shift_out && !second.valid) begin
         flush_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff <= 1'b0;
      end else begin
         flush_ff <= flush_in;
      end
   end

   rsr_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .beat       (beat),
      .rsp_tready (rsp_tready),
      .valid_ff   (rsp_tvalid),
      .beat_ff    (beat_ff)
   );

   assign rsp_tdata = beat_ff.symbol;
   assign rsp_tlast = beat_ff.run_end;
   assign rsp_tuser = beat_ff.stream_end;

endmodule

`default_nettype wire

### rtl/rsr_check.sv
// port-level checks of the run generator, bound to the top level
// depends on rsr_pkg and replacement_selection_runs_top_assert.svh
`default_nettype none

`include "replacement_selection_runs_top_assert.svh"

module rsr_check
   import rsr_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             req_tlast,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [SYM_W-1:0] rsp_tdata,
   input wire logic             rsp_tlast,
   input wire logic             rsp_tuser
);

   // a stalled result beat stays put
   `RSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable({rsp_tdata, rsp_tlast, rsp_tuser}))

   // the last beat of the stream also closes its run
   `RSR_ASSERT_IMPLY(a_stream_end_run, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   // the final byte is always followed by a flush that blocks new input
   `RSR_ASSERT_NEXT(a_flush_stall, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

   // after the final byte is taken, the flush flag is set and then the output register holds a valid beat
   `RSR_ASSERT_NEXT(a_flush_emits, clock, reset, req_tvalid && req_tready && req_tlast, ##1 rsp_tvalid)

endmodule

bind replacement_selection_runs_top rsr_check u_rsr_check (.*);

`default_nettype wire
